[rtl/core/lsu_pkg.sv]
// Shared types and constants for the literal string unescaper.
// No dependencies; imported by every module of the block.
package lsu_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [4:0] OCT_HI    = 5'b00110;   // '0'..'7' share these upper bits

    localparam logic [1:0] OCT_IDLE  = 2'd0;
    localparam logic [1:0] OCT_LAST  = 2'd2;       // two digits held, next one closes

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;
    localparam logic [Q_CNT_W-1:0] Q_ROOM2 = 3'd2; // count at or below this leaves room for two

    typedef struct packed {
        logic [7:0] data;
        logic       str_end;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               room;
    } t_q_status;

endpackage

[rtl/core/lsu_decode.sv]
// Input register, escape/nesting state and the single-pass byte decoder.
// Depends on lsu_pkg; produces up to two results per request for lsu_outq.
module lsu_decode
    import lsu_pkg::*;
#(
    parameter int DEPTH_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_room,
    output t_push       o_push
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_esc;
    logic [1:0]            r_ocnt;
    logic [8:0]            r_oval;
    logic [DEPTH_BITS-1:0] r_depth;

    logic                  n_esc;
    logic [1:0]            n_ocnt;
    logic [8:0]            n_oval;
    logic [DEPTH_BITS-1:0] n_depth;

    logic                  fire;
    logic                  is_oct;
    logic                  fresh_go;
    logic                  fr_emit;
    logic [7:0]            fr_data;
    logic                  fr_end;
    logic [8:0]            oval_sh;
    logic [1:0]            cnt;
    t_result               res0;
    t_result               res1;

    assign fire       = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || i_room;
    assign is_oct     = (r_in_byte[7:3] == OCT_HI);
    assign oval_sh    = {r_oval[5:0], r_in_byte[2:0]};

    always_comb begin
        n_esc    = r_esc;
        n_ocnt   = r_ocnt;
        n_oval   = r_oval;
        n_depth  = r_depth;
        cnt      = 2'd0;
        res0     = '0;
        res1     = '0;
        fresh_go = 1'b1;
        fr_emit  = 1'b0;
        fr_data  = r_in_byte;
        fr_end   = 1'b0;

        if (r_ocnt != OCT_IDLE) begin
            if (is_oct) begin
                fresh_go = 1'b0;
                if (r_ocnt == OCT_LAST) begin
                    res0.data = oval_sh[7:0];
                    cnt       = 2'd1;
                    n_ocnt    = OCT_IDLE;
                    n_oval    = '0;
                end else begin
                    n_ocnt = r_ocnt + 2'd1;
                    n_oval = oval_sh;
                end
            end else begin
                // cut-short octal escape: flush digits, then treat byte as new
                res0.data = r_oval[7:0];
                cnt       = 2'd1;
                n_ocnt    = OCT_IDLE;
                n_oval    = '0;
            end
        end

        if (fresh_go) begin
            if (r_esc) begin
                n_esc   = 1'b0;
                fr_emit = 1'b1;
                case (r_in_byte)
                    CH_LC_N: fr_data = CH_LF;
                    CH_LC_R: fr_data = CH_CR;
                    CH_LC_B: fr_data = CH_BS;
                    default: begin
                        if (is_oct) begin
                            fr_emit = 1'b0;
                            n_ocnt  = 2'd1;
                            n_oval  = {6'd0, r_in_byte[2:0]};
                        end
                    end
                endcase
            end else begin
                case (r_in_byte)
                    CH_BSLASH: n_esc = 1'b1;
                    CH_OPEN: begin
                        fr_emit = 1'b1;
                        if (!(&r_depth))
                            n_depth = r_depth + DEPTH_BITS'(1);
                    end
                    CH_CLOSE: begin
                        fr_emit = 1'b1;
                        if (r_depth == '0) begin
                            fr_end  = 1'b1;
                            fr_data = 8'd0;
                            n_esc   = 1'b0;
                            n_ocnt  = OCT_IDLE;
                            n_oval  = '0;
                        end else begin
                            n_depth = r_depth - DEPTH_BITS'(1);
                        end
                    end
                    default: fr_emit = 1'b1;
                endcase
            end

            if (fr_emit) begin
                if (cnt == 2'd0) begin
                    res0.data    = fr_data;
                    res0.str_end = fr_end;
                end else begin
                    res1.data    = fr_data;
                    res1.str_end = fr_end;
                end
                cnt = cnt + 2'd1;
            end
        end

        if (cnt == 2'd1) res0.last = 1'b1;
        if (cnt == 2'd2) res1.last = 1'b1;
    end

    assign o_push.n  = fire ? cnt : 2'd0;
    assign o_push.r0 = res0;
    assign o_push.r1 = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_esc      <= 1'b0;
            r_ocnt     <= OCT_IDLE;
            r_oval     <= '0;
            r_depth    <= '0;
        end else begin
            if (o_in_ready)
                r_in_valid <= i_in_valid;
            if (fire) begin
                r_esc   <= n_esc;
                r_ocnt  <= n_ocnt;
                r_oval  <= n_oval;
                r_depth <= n_depth;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid)
            r_in_byte <= i_in_byte;
    end

endmodule

[rtl/core/lsu_outq.sv]
// Four-entry result queue: takes up to two results per cycle, gives one.
// Depends on lsu_pkg; feeds the output channel of the top level.
module lsu_outq
    import lsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  logic      i_pop,
    output t_result   o_head,
    output t_q_status o_status
);

    t_result            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;
    logic [Q_PTR_W-1:0] wp_next;

    assign wp_next = r_wp + Q_PTR_W'(1);
    assign n_count = r_count + Q_CNT_W'(i_push.n) - Q_CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + Q_PTR_W'(i_push.n);
            if (i_pop)
                r_rp <= r_rp + Q_PTR_W'(1);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0)
            r_mem[r_wp] <= i_push.r0;
        if (i_push.n == 2'd2)
            r_mem[wp_next] <= i_push.r1;
    end

    assign o_head         = r_mem[r_rp];
    assign o_status.count = r_count;
    assign o_status.room  = (r_count <= Q_ROOM2);

endmodule

[rtl/core/literal_string_unescaper.sv]
// Top level of the literal string unescaper.
// Depends on lsu_pkg, lsu_decode and lsu_outq.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_byte) takes the body bytes
//   of a literal string, one per request, starting after the opening paren.
//   Output channel (o_out_valid / i_out_ready) gives one unescaped byte per
//   request. o_string_end marks the closing paren at depth zero (o_out_byte
//   is zero then); o_last flags the final result caused by an input byte.
//   A byte is registered, decoded in one pass and written to a four-entry
//   result queue that feeds the output. Throughput: one byte per cycle
//   while the receiver is ready and each byte gives at most one result; a
//   byte that flushes a cut-short octal escape gives two results, and the
//   single-result output port sets the rate.
//   Input is taken while the queue has room for two results, so a waiting
//   result never blocks the decoder by itself.
//   Reset (synchronous, active low) clears escape, octal and depth state and
//   empties the queue. When the receiver stalls the queue fills, then
//   o_in_ready drops; nothing is lost or repeated.
module literal_string_unescaper
    import lsu_pkg::*;
#(
    parameter int DEPTH_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_string_end,
    output logic       o_last
);

    t_push     push;
    t_result   head;
    t_q_status qst;
    logic      pop;

    lsu_decode #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_room     (qst.room),
        .o_push     (push)
    );

    lsu_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (qst)
    );

    assign o_out_valid  = (qst.count != '0);
    assign pop          = o_out_valid && i_out_ready;
    assign o_out_byte   = head.data;
    assign o_string_end = head.str_end;
    assign o_last       = head.last;

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qst.count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.n != 2'd0) |-> qst.room)
        else $error("push without room in result queue");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_string_end) |-> (o_out_byte == 8'd0 && o_last))
        else $error("string end result carries data or is not last");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.n == 2'd0 && !pop) |=> $stable(qst.count))
        else $error("queue count moved without push or pop");

endmodule

[bench/unescape_checker.sv]
`timescale 1ns / 1ps
// Checker for the literal string unescaper: follows both channels, keeps its
// own unescape state and compares every output request. Depends on lsu_pkg.
module unescape_checker
    import lsu_pkg::*;
#(
    parameter int DEPTH_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_string_end,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_waiting
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    logic                  esc_pend;
    logic [1:0]            oct_cnt;
    logic [8:0]            oct_val;
    logic [DEPTH_BITS-1:0] nest;

    t_result unescaped_q[$];
    t_result staged[2];
    int      n_staged;
    int      n_fail = 0;

    assign o_fail_count = n_fail;

    initial o_waiting = 0;

    function automatic logic is_octal(input logic [7:0] b);
        return b[7:3] == OCT_HI;
    endfunction

    task automatic stage(input logic [7:0] b, input logic e);
        staged[n_staged] = {b, e, 1'b0};
        n_staged++;
    endtask

    // byte seen with no octal escape open
    task automatic unescape_fresh(input logic [7:0] b);
        if (esc_pend) begin
            esc_pend = 1'b0;
            if (b == CH_LC_N) begin
                stage(CH_LF, 1'b0);
            end else if (b == CH_LC_R) begin
                stage(CH_CR, 1'b0);
            end else if (b == CH_LC_B) begin
                stage(CH_BS, 1'b0);
            end else if (is_octal(b)) begin
                oct_cnt = 2'd1;
                oct_val = {6'd0, b[2:0]};
            end else begin
                stage(b, 1'b0);
            end
        end else if (b == CH_BSLASH) begin
            esc_pend = 1'b1;
        end else if (b == CH_OPEN) begin
            if (nest != DEPTH_MAX) nest = nest + DEPTH_BITS'(1);
            stage(b, 1'b0);
        end else if (b == CH_CLOSE) begin
            if (nest == '0) begin
                esc_pend = 1'b0;
                oct_cnt  = OCT_IDLE;
                oct_val  = '0;
                stage(8'h00, 1'b1);
            end else begin
                nest = nest - DEPTH_BITS'(1);
                stage(b, 1'b0);
            end
        end else begin
            stage(b, 1'b0);
        end
    endtask

    task automatic predict_unescape(input logic [7:0] b);
        n_staged = 0;
        if (oct_cnt != OCT_IDLE) begin
            if (is_octal(b)) begin
                oct_val = {oct_val[5:0], b[2:0]};
                if (oct_cnt == OCT_LAST) begin
                    stage(oct_val[7:0], 1'b0);
                    oct_cnt = OCT_IDLE;
                    oct_val = '0;
                end else begin
                    oct_cnt = oct_cnt + 2'd1;
                end
            end else begin
                // cut-short escape: flush digits, then treat the byte as new
                stage(oct_val[7:0], 1'b0);
                oct_cnt = OCT_IDLE;
                oct_val = '0;
                unescape_fresh(b);
            end
        end else begin
            unescape_fresh(b);
        end
        for (int i = 0; i < n_staged; i++) begin
            if (i == n_staged - 1) staged[i].last = 1'b1;
            unescaped_q.insert(unescaped_q.size(), staged[i]);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            esc_pend = 1'b0;
            oct_cnt  = OCT_IDLE;
            oct_val  = '0;
            nest     = '0;
            unescaped_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_unescape(i_in_byte);
            if (i_out_valid && i_out_ready) begin
                got = {i_out_byte, i_string_end, i_last};
                if (unescaped_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h/%b/%b",
                             $time, got.data, got.str_end, got.last);
                    n_fail++;
                end else begin
                    want = unescaped_q.pop_front();
                    if (got.data !== want.data) begin
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $time, want.data, got.data);
                        n_fail++;
                    end
                    if (got.str_end !== want.str_end) begin
                        $display("%0t: string_end mismatch: expected %b, actual %b",
                                 $time, want.str_end, got.str_end);
                        n_fail++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, got.last);
                        n_fail++;
                    end
                end
            end
        end
        o_waiting <= unescaped_q.size();
    end

endmodule

[bench/literal_string_unescaper_test.sv]
`timescale 1ns / 1ps
// Top of the unescaper bench: clock, reset, byte stimulus and verdict.
// Depends on lsu_pkg, unescape_checker and the literal_string_unescaper RTL.
module literal_string_unescaper_test;
    import lsu_pkg::*;

    localparam int DEPTH_BITS   = 8;
    localparam int RANDOM_ITEMS = 360;
    localparam int LIMIT        = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_string_end;
    logic       o_last;

    int n_fail;
    int n_waiting;
    int n_sent         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_tab[4]    = '{0, 79, 0, 28};
    int stall_tab[4]   = '{0, 0, 79, 28};

    logic [7:0] directed_q[$];

    always #5 i_clk = ~i_clk;

    literal_string_unescaper #(
        .DEPTH_BITS(DEPTH_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_string_end(o_string_end),
        .o_last      (o_last)
    );

    unescape_checker #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_byte  (o_out_byte),
        .i_string_end(o_string_end),
        .i_last      (o_last),
        .o_fail_count(n_fail),
        .o_waiting   (n_waiting)
    );

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [7:0] octal_digit();
        return {OCT_HI, 3'($urandom)};
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_BSLASH || b == CH_OPEN || b == CH_CLOSE);
        return b;
    endfunction

    function automatic logic [7:0] non_octal_char();
        logic [7:0] b;
        do b = 8'($urandom); while (b[7:3] == OCT_HI);
        return b;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_byte  <= 8'($urandom);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic wait_drained();
        while (n_waiting != 0) @(negedge i_clk);
    endtask

    // one short, mostly well-formed piece of string body
    task automatic send_sequence();
        logic [7:0] seq[$];
        int         sel;
        int         k;
        sel = $urandom_range(99);
        if (sel < 30) begin
            k = $urandom_range(6, 1);
            repeat (k) seq = {seq, plain_char()};
        end else if (sel < 45) begin
            seq = {seq, CH_BSLASH};
            case ($urandom_range(6))
                0:       seq = {seq, CH_LC_N};
                1:       seq = {seq, CH_LC_R};
                2:       seq = {seq, CH_LC_B};
                3:       seq = {seq, CH_OPEN};
                4:       seq = {seq, CH_CLOSE};
                5:       seq = {seq, CH_BSLASH};
                default: seq = {seq, 8'($urandom)};
            endcase
        end else if (sel < 65) begin
            seq = {seq, CH_BSLASH};
            k = $urandom_range(3, 1);
            repeat (k) seq = {seq, octal_digit()};
            if (k < 3) begin
                case ($urandom_range(3))
                    0:       seq = {seq, CH_BSLASH};
                    1:       seq = {seq, CH_CLOSE};
                    2:       seq = {seq, CH_OPEN};
                    default: seq = {seq, non_octal_char()};
                endcase
            end else if ($urandom_range(1)) begin
                seq = {seq, octal_digit()};
            end
        end else if (sel < 75) begin
            seq = {seq, CH_OPEN};
        end else if (sel < 85) begin
            seq = {seq, CH_CLOSE};
        end else if (sel < 95) begin
            seq = {seq, CH_OPEN};
            k = $urandom_range(3);
            repeat (k) seq = {seq, plain_char()};
            seq = {seq, CH_CLOSE};
        end else begin
            k = $urandom_range(4, 1);
            repeat (k) seq = {seq, 8'($urandom)};
        end
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int phase_end;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, every escape, truncated and cut-short octal, string end
        directed_q = '{8'h00, 8'hFF,
                       CH_BSLASH, CH_LC_N, CH_BSLASH, CH_LC_R, CH_BSLASH, CH_LC_B,
                       CH_BSLASH, CH_OPEN, CH_BSLASH, CH_BSLASH, CH_BSLASH, 8'h71,
                       CH_BSLASH, {OCT_HI, 3'd7}, {OCT_HI, 3'd7}, {OCT_HI, 3'd7},
                       CH_BSLASH, {OCT_HI, 3'd4}, 8'h78,
                       CH_BSLASH, {OCT_HI, 3'd5}, {OCT_HI, 3'd6}, CH_BSLASH, CH_LC_N,
                       CH_BSLASH, {OCT_HI, 3'd1}, CH_CLOSE,
                       CH_OPEN, CH_CLOSE, CH_CLOSE};
        foreach (directed_q[i]) send_byte(directed_q[i]);
        i_in_valid <= 1'b0;
        wait_drained();

        // depth saturation: open past the maximum, then close back to the end
        repeat (260) send_byte(CH_OPEN);
        repeat (256) send_byte(CH_CLOSE);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            phase_end      = n_sent + RANDOM_ITEMS / 4;
            while (n_sent < phase_end) send_sequence();
            i_in_valid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
